// ----- src/breakpoint_window_dedup_top_macros.svh -----
// Assertion macros shared by the breakpoint window dedup RTL.
// Files that check their own logic include this header; define ASSERT_OFF to drop the checks.
`ifndef BREAKPOINT_WINDOW_DEDUP_TOP_MACROS_SVH
`define BREAKPOINT_WINDOW_DEDUP_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define BWD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be true outside reset.
`define BWD_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BWD_ASSERT(name, prop, msg)
`define BWD_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ----- src/bwd_pkg.sv -----
// Shared types and constants of the breakpoint window dedup block.
// No dependencies; imported by the sequencer, the compare unit and the top level.
package bwd_pkg;

  localparam int CHROM_W   = 8;
  localparam int POS_W     = 28;
  localparam int RANK_W    = 4;
  localparam int FRAC_W    = 16;
  localparam int FRAC_BITS = 12;
  localparam int MAXDEV_W  = 20;
  localparam int PROD_W    = FRAC_W + POS_W;
  localparam int TOL_W     = PROD_W - FRAC_BITS;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_FRAC   = 2'd0;
  localparam logic [1:0] REG_MAXDEV = 2'd1;
  localparam logic [1:0] REG_EMIT   = 2'd2;

  localparam logic [FRAC_W-1:0]   FRAC_RST   = 16'd1229;
  localparam logic [MAXDEV_W-1:0] MAXDEV_RST = 20'd200;
  localparam logic                EMIT_RST   = 1'b0;

  typedef struct packed {
    logic [FRAC_W-1:0]   frac;
    logic [MAXDEV_W-1:0] max_dev;
    logic                emit_cov;
  } cfg_t;

  typedef struct packed {
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   end_pos;
    logic [RANK_W-1:0]  rank;
    logic               eos;
  } item_t;

  // One window entry as stored in RAM
  typedef struct packed {
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   end_pos;
    logic [RANK_W-1:0]  rank;
    logic               covered;
  } entry_t;

  // Sequencer to output stage: push a released call, or close the current call
  typedef struct packed {
    logic   push;
    logic   forced;
    logic   close;
    entry_t ent;
  } rel_t;

  typedef struct packed {
    logic start_late;
    logic end_near;
  } cmp_res_t;

endpackage

// ----- src/bwd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bwd_cmp.sv -----
// Breakpoint compare unit: signed start distance and absolute end distance against a limit.
// Depends on bwd_pkg. Shared by the scan and the ageing steps.
module bwd_cmp (
  input  logic [bwd_pkg::POS_W-1:0]    a_start_i,
  input  logic [bwd_pkg::POS_W-1:0]    a_end_i,
  input  logic [bwd_pkg::POS_W-1:0]    b_start_i,
  input  logic [bwd_pkg::POS_W-1:0]    b_end_i,
  input  logic [bwd_pkg::MAXDEV_W-1:0] limit_i,
  output bwd_pkg::cmp_res_t            res_o
);
  import bwd_pkg::*;

  logic [POS_W:0]   ds;
  logic [POS_W:0]   de;
  logic [POS_W:0]   de_neg;
  logic [POS_W-1:0] de_mag;
  logic [POS_W-1:0] lim;

  assign lim    = POS_W'(limit_i);
  assign ds     = {1'b0, a_start_i} - {1'b0, b_start_i};
  assign de     = {1'b0, a_end_i} - {1'b0, b_end_i};
  assign de_neg = ~de + (POS_W+1)'(1);
  assign de_mag = de[POS_W] ? de_neg[POS_W-1:0] : de[POS_W-1:0];

  // A negative start distance is never late
  assign res_o.start_late = !ds[POS_W] && (ds[POS_W-1:0] > lim);
  assign res_o.end_near   = (de_mag <= lim);

endmodule

// ----- src/bwd_seq.sv -----
// Window sequencer: tolerance, chromosome flush, newest-first scan, ageing and release.
// Depends on bwd_pkg, bwd_ram, bwd_cmp and the assertion macro header.
`include "breakpoint_window_dedup_top_macros.svh"

module bwd_seq #(
  parameter int DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bwd_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bwd_pkg::item_t      item_i,
  input  logic                rel_ready_i,
  output bwd_pkg::rel_t       rel_o
);
  import bwd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_TOL   = 4'd2;
  localparam logic [3:0] S_CHG   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_AGEF  = 4'd5;
  localparam logic [3:0] S_AGE   = 4'd6;
  localparam logic [3:0] S_FULL  = 4'd7;
  localparam logic [3:0] S_STORE = 4'd8;
  localparam logic [3:0] S_EOSF  = 4'd9;
  localparam logic [3:0] S_EOS   = 4'd10;
  localparam logic [3:0] S_CLOSE = 4'd11;

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [3:0]          state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       left_q, left_d;
  logic                new_cov_q, new_cov_d;
  logic [MAXDEV_W-1:0] tol_q, tol_d;
  logic [TOL_W-1:0]    prod_q, prod_d;
  item_t               item_q;

  logic [PROD_W-1:0]   prod_full;
  logic [POS_W-1:0]    len;
  logic [MAXDEV_W-1:0] tol_cap;
  logic [AW-1:0]       newest;
  logic [AW-1:0]       tail;
  logic [AW-1:0]       head_nx;
  logic [AW-1:0]       ptr_prev;

  logic                ren;
  logic [AW-1:0]       raddr;
  logic                we;
  logic [AW-1:0]       waddr;
  entry_t              wdata;
  entry_t              rd;

  logic [MAXDEV_W-1:0] lim;
  cmp_res_t            cmp;

  logic                rel_vis;
  logic                rel_go;
  logic                rel_take;
  logic                rel_forced;
  logic                rel_close;

  bwd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_win (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ren),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  assign lim = (state_q == S_AGE) ? cfg_i.max_dev : tol_q;

  bwd_cmp u_cmp (
    .a_start_i (item_q.start_pos),
    .a_end_i   (item_q.end_pos),
    .b_start_i (rd.start_pos),
    .b_end_i   (rd.end_pos),
    .limit_i   (lim),
    .res_o     (cmp)
  );

  assign len       = item_q.end_pos - item_q.start_pos;
  assign prod_full = {{POS_W{1'b0}}, cfg_i.frac} * {{FRAC_W{1'b0}}, len};
  assign tol_cap   = (prod_q > TOL_W'(cfg_i.max_dev)) ? cfg_i.max_dev
                                                      : prod_q[MAXDEV_W-1:0];

  assign newest   = slot_add(head_q, count_q - CW'(1));
  assign tail     = slot_add(head_q, count_q);
  assign head_nx  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign ptr_prev = (ptr_q == '0) ? AW'(DEPTH - 1) : ptr_q - AW'(1);

  // A suppressed covered call needs no room downstream
  assign rel_vis = !rd.covered || cfg_i.emit_cov;
  assign rel_go  = !rel_vis || rel_ready_i;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    left_d     = left_q;
    new_cov_d  = new_cov_q;
    tol_d      = tol_q;
    prod_d     = prod_q;
    ren        = 1'b0;
    raddr      = head_q;
    we         = 1'b0;
    waddr      = ptr_q;
    wdata      = rd;
    rel_take   = 1'b0;
    rel_forced = 1'b0;
    rel_close  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        new_cov_d = 1'b0;
        if (in_valid_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = prod_full[PROD_W-1:FRAC_BITS];
        ren     = (count_q != '0);
        raddr   = newest;
        state_d = S_TOL;
      end
      S_TOL: begin
        tol_d = tol_cap;
        if (count_q != '0 && rd.chrom != item_q.chrom) begin
          ren     = 1'b1;
          raddr   = head_q;
          state_d = S_CHG;
        end else if (count_q != '0 && item_q.end_pos >= item_q.start_pos) begin
          // newest entry is already on the read port
          ptr_d   = newest;
          left_d  = count_q;
          state_d = S_SCAN;
        end else if (count_q != '0) begin
          ren     = 1'b1;
          raddr   = head_q;
          state_d = S_AGE;
        end else begin
          state_d = S_STORE;
        end
      end
      S_CHG: begin
        if (rel_go) begin
          rel_take = 1'b1;
          if (count_q == CW'(1)) begin
            state_d = S_STORE;
          end else begin
            ren   = 1'b1;
            raddr = head_nx;
          end
        end
      end
      S_SCAN: begin
        if (cmp.start_late) begin
          state_d = S_AGEF;
        end else begin
          if (rd.chrom == item_q.chrom && !rd.covered && cmp.end_near) begin
            if (item_q.rank <= rd.rank) begin
              we            = 1'b1;
              waddr         = ptr_q;
              wdata.covered = 1'b1;
            end else begin
              new_cov_d = 1'b1;
            end
          end
          if (left_q == CW'(1)) begin
            state_d = S_AGEF;
          end else begin
            ptr_d  = ptr_prev;
            left_d = left_q - CW'(1);
            ren    = 1'b1;
            raddr  = ptr_prev;
          end
        end
      end
      S_AGEF: begin
        // refetch head after the scan may have rewritten it
        ren     = 1'b1;
        raddr   = head_q;
        state_d = S_AGE;
      end
      S_AGE: begin
        if (cmp.start_late) begin
          if (rel_go) begin
            rel_take = 1'b1;
            if (count_q == CW'(1)) begin
              state_d = S_STORE;
            end else begin
              ren   = 1'b1;
              raddr = head_nx;
            end
          end
        end else if (count_q == CW'(DEPTH)) begin
          state_d = S_FULL;
        end else begin
          state_d = S_STORE;
        end
      end
      S_FULL: begin
        if (rel_go) begin
          rel_take   = 1'b1;
          rel_forced = 1'b1;
          state_d    = S_STORE;
        end
      end
      S_STORE: begin
        we              = 1'b1;
        waddr           = tail;
        wdata.chrom     = item_q.chrom;
        wdata.start_pos = item_q.start_pos;
        wdata.end_pos   = item_q.end_pos;
        wdata.rank      = item_q.rank;
        wdata.covered   = new_cov_q;
        count_d         = count_q + CW'(1);
        state_d         = item_q.eos ? S_EOSF : S_CLOSE;
      end
      S_EOSF: begin
        ren     = 1'b1;
        raddr   = head_q;
        state_d = S_EOS;
      end
      S_EOS: begin
        if (rel_go) begin
          rel_take = 1'b1;
          if (count_q == CW'(1)) begin
            state_d = S_CLOSE;
          end else begin
            ren   = 1'b1;
            raddr = head_nx;
          end
        end
      end
      S_CLOSE: begin
        rel_close = rel_ready_i;
        if (rel_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (rel_take) begin
      head_d  = head_nx;
      count_d = count_q - CW'(1);
    end
  end

  assign rel_o.push   = rel_take && rel_vis;
  assign rel_o.forced = rel_forced;
  assign rel_o.close  = rel_close;
  assign rel_o.ent    = rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      ptr_q     <= '0;
      left_q    <= '0;
      new_cov_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      left_q    <= left_d;
      new_cov_q <= new_cov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tol_q  <= tol_d;
    prod_q <= prod_d;
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= item_i;
    end
  end

  `BWD_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "window count above depth")
  `BWD_ASSERT(a_full_release, (state_q == S_FULL) |-> (count_q == CW'(DEPTH)), "forced release with room left")
  `BWD_ASSERT(a_store_grows, (state_q == S_STORE) |=> (count_q == $past(count_q) + CW'(1)), "store did not grow window")
  `BWD_ASSERT_NEVER(a_push_outside_release, rel_o.push && (state_q == S_SCAN || state_q == S_STORE), "release outside a release step")

endmodule

// ----- src/breakpoint_window_dedup_top.sv -----
// Top level of the breakpoint window dedup block: APB registers, output staging, sequencer.
// Depends on bwd_pkg, bwd_seq (with bwd_ram and bwd_cmp) and the assertion macro header.
//
//  channel | direction | handshake               | word
//  in      | sink      | in_valid_i / in_stall_o | chrom, start, end, rank, end_of_stream
//  out     | source    | out_valid_o/out_stall_i | released call with covered, forced, final
//  cfg     | APB slave | psel/penable/pready     | three registers at 0x0, 0x4, 0x8
//
// One call at a time; in_stall_o is low only while the sequencer is idle.
// A call's time grows with the entries scanned and the entries released, plus a
// window refetch and an extra step with end_of_stream. The window RAM's single read
// port reads one entry per cycle while no release is held back by the output.
// Reset empties the window (count and head); RAM contents are left as they are.
// out_stall_i holds the sequencer only when both the hold stage and the output word are full.
`include "breakpoint_window_dedup_top_macros.svh"

module breakpoint_window_dedup_top #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bwd_pkg::CHROM_W-1:0]   chrom_id_i,
  input  logic [bwd_pkg::POS_W-1:0]     start_pos_i,
  input  logic [bwd_pkg::POS_W-1:0]     end_pos_i,
  input  logic [bwd_pkg::RANK_W-1:0]    caller_rank_i,
  input  logic                          end_of_stream_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bwd_pkg::CHROM_W-1:0]   out_chrom_o,
  output logic [bwd_pkg::POS_W-1:0]     out_start_o,
  output logic [bwd_pkg::POS_W-1:0]     out_end_o,
  output logic [bwd_pkg::RANK_W-1:0]    out_rank_o,
  output logic                          covered_o,
  output logic                          forced_out_o,
  output logic                          final_of_run_o,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bwd_pkg::ADDR_W-1:0]    paddr,
  input  logic [bwd_pkg::DATA_W-1:0]    pwdata,
  output logic [bwd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import bwd_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  item_t      item;
  rel_t       rel;
  logic       rel_ready;

  logic       pend_valid_q, pend_valid_d;
  entry_t     pend_q;
  logic       pend_forced_q;
  logic       out_valid_q, out_valid_d;
  entry_t     out_q;
  logic       out_forced_q;
  logic       out_final_q;
  logic       out_free;
  logic       load_out;

  // Configuration registers
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frac     <= FRAC_RST;
      cfg_q.max_dev  <= MAXDEV_RST;
      cfg_q.emit_cov <= EMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAC:   cfg_q.frac     <= pwdata[FRAC_W-1:0];
        REG_MAXDEV: cfg_q.max_dev  <= pwdata[MAXDEV_W-1:0];
        REG_EMIT:   cfg_q.emit_cov <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAC:   prdata = DATA_W'(cfg_q.frac);
      REG_MAXDEV: prdata = DATA_W'(cfg_q.max_dev);
      REG_EMIT:   prdata = DATA_W'(cfg_q.emit_cov);
      default:    prdata = '0;
    endcase
  end

  assign item.chrom     = chrom_id_i;
  assign item.start_pos = start_pos_i;
  assign item.end_pos   = end_pos_i;
  assign item.rank      = caller_rank_i;
  assign item.eos       = end_of_stream_i;

  bwd_seq #(
    .DEPTH (WINDOW_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (item),
    .rel_ready_i (rel_ready),
    .rel_o       (rel)
  );

  // Hold the latest release until we know whether it is the last of its call
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rel_ready = !pend_valid_q || out_free;
  assign load_out  = (rel.push || rel.close) && pend_valid_q;

  always_comb begin
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
    pend_valid_d = pend_valid_q;
    if (rel.push) begin
      pend_valid_d = 1'b1;
    end else if (rel.close) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q        <= pend_q;
      out_forced_q <= pend_forced_q;
      out_final_q  <= rel.close;
    end
    if (rel.push) begin
      pend_q        <= rel.ent;
      pend_forced_q <= rel.forced;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_chrom_o    = out_q.chrom;
  assign out_start_o    = out_q.start_pos;
  assign out_end_o      = out_q.end_pos;
  assign out_rank_o     = out_q.rank;
  assign covered_o      = out_q.covered;
  assign forced_out_o   = out_forced_q;
  assign final_of_run_o = out_final_q;

  `BWD_ASSERT_NEVER(a_push_and_close, rel.push && rel.close, "push and close in one cycle")
  `BWD_ASSERT(a_rel_has_room, (rel.push || rel.close) |-> rel_ready, "release with no room")
  `BWD_ASSERT(a_close_drains, rel.close |=> !pend_valid_q, "hold stage not drained at close")

endmodule
